### src/ncrc_pkg.sv
// Shared types, constants and fixed-point helpers for the Newton cubic root classifier.
// Used by the controller, the datapath and the divider lanes. No dependencies.
package ncrc_pkg;

  localparam int FRAC_BITS = 28;
  localparam int DIV_STEPS = 31;

  localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
  localparam logic signed [65:0] S32_MIN = -66'sd2147483648;

  typedef enum logic [2:0] {
    CFG_ROOT0_RE,
    CFG_ROOT0_IM,
    CFG_ROOT1_RE,
    CFG_ROOT1_IM,
    CFG_ROOT2_RE,
    CFG_ROOT2_IM,
    CFG_TOLERANCE,
    CFG_MAX_ITER
  } cfg_idx_t;

  typedef enum logic [4:0] {
    MS_BR_CR, MS_BI_CI, MS_BR_CI, MS_BI_CR,
    MS_AR_CR, MS_AI_CI, MS_AR_CI, MS_AI_CR,
    MS_AR_BR, MS_AI_BI, MS_AR_BI, MS_AI_BR,
    MS_AR_BCR, MS_AI_BCI, MS_AR_BCI, MS_AI_BCR,
    MS_DR_DR, MS_DI_DI,
    MS_VR_DR, MS_VI_DI, MS_VI_DR, MS_VR_DI,
    MS_ER_ER, MS_EI_EI, MS_TOL_SQ,
    MS_DX0, MS_DY0, MS_DX1, MS_DY1, MS_DX2, MS_DY2
  } mstep_t;

  typedef enum logic [3:0] {
    S_IDLE, S_TEST, S_ABC, S_MUL_A, S_CHK, S_DIVI, S_DIV, S_UPD,
    S_MUL_C, S_CONVW, S_DEC, S_MUL_D, S_DISTW, S_FIN
  } state_t;

  typedef struct packed {
    logic   load;
    logic   abc;
    logic   mul_en;
    mstep_t mstep;
    logic   div_init;
    logic   div_step;
    logic   upd;
    logic   set_zder;
    logic   out_load;
  } cmd_t;

  typedef struct packed {
    logic at_limit;
    logic den_zero;
    logic conv;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [65:0] y;
    begin
      y = x;
      if (x > S32_MAX) y = S32_MAX;
      if (x < S32_MIN) y = S32_MIN;
      return y[31:0];
    end
  endfunction

  function automatic logic signed [32:0] ext33(input logic signed [31:0] x);
    return {x[31], x};
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    begin
      s = ext33(a) + ext33(b);
      return sat32({{33{s[32]}}, s});
    end
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    begin
      s = ext33(a) - ext33(b);
      return sat32({{33{s[32]}}, s});
    end
  endfunction

  // Product scaled down with rounding toward minus infinity, then saturated.
  function automatic logic signed [31:0] fmul(input logic signed [65:0] p);
    logic signed [65:0] sh;
    begin
      sh = p >>> FRAC_BITS;
      return sat32(sh);
    end
  endfunction

endpackage

### src/newton_cubic_root_classifier.sv
// Top level of the Newton cubic root classifier: controller plus datapath.
// Depends on ncrc_pkg, ncrc_ctrl and ncrc_datapath.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    in_start_re, in_start_im
//   out      output     out_valid/out_ready  root_index, iterations_used, flags, final_re/im
//   cfg      input      cfg_we               cfg_index, cfg_wdata
//
// Each Newton step of a point is 22 passes through the single 33x33 multiplier, a 31-bit
// division in the two divider lanes and 3 more multiplier passes for the tolerance test;
// a point also goes through accept, root search and output. A zero derivative ends the
// Newton steps after the 22 multiplier passes of that step and goes on to root search.
// Reset is synchronous and loads the default roots, tolerance and limit.
// A finished result waits in the output register while the next point is accepted and
// worked on; a point whose result finds the register still full waits until it drains.
module newton_cubic_root_classifier
  import ncrc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_start_re,
  input  logic signed [31:0] in_start_im,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_root_index,
  output logic [15:0]        out_iterations_used,
  output logic               out_converged,
  output logic               out_zero_derivative,
  output logic signed [31:0] out_final_re,
  output logic signed [31:0] out_final_im
);

  cmd_t    cmd;
  status_t status;

  ncrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  ncrc_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_idx_t'(cfg_index)),
    .cfg_wdata           (cfg_wdata),
    .in_start_re         (in_start_re),
    .in_start_im         (in_start_im),
    .cmd                 (cmd),
    .status              (status),
    .out_root_index      (out_root_index),
    .out_iterations_used (out_iterations_used),
    .out_converged       (out_converged),
    .out_zero_derivative (out_zero_derivative),
    .out_final_re        (out_final_re),
    .out_final_im        (out_final_im)
  );

endmodule

### src/ncrc_divlane.sv
// Restoring divider lane: one quotient bit per cycle while step is high, result saturated to 32 bits.
// Depends on ncrc_pkg.
module ncrc_divlane
  import ncrc_pkg::*;
(
  input  logic               clk,
  input  logic               init,
  input  logic               step,
  input  logic [63:0]        mag,
  input  logic               neg,
  input  logic [63:0]        den,
  output logic signed [31:0] quot
);

  localparam int NW = 64 + FRAC_BITS;

  logic [NW-1:0] num;
  logic [NW-1:0] top;
  logic [63:0]   rem_r;
  logic [30:0]   nlow_r;
  logic [30:0]   q_r;
  logic          ovf_r;
  logic          neg_r;
  logic [64:0]   r2;
  logic [31:0]   qext;

  assign num  = {mag, {FRAC_BITS{1'b0}}};
  assign top  = num >> DIV_STEPS;
  assign r2   = {rem_r, nlow_r[30]};
  assign qext = {1'b0, q_r};

  always_ff @(posedge clk) begin
    if (init) begin
      rem_r  <= top[63:0];
      nlow_r <= num[30:0];
      ovf_r  <= (top >= NW'(den));
      neg_r  <= neg;
    end else if (step) begin
      nlow_r <= {nlow_r[29:0], 1'b0};
      if (r2 >= {1'b0, den}) begin
        rem_r <= 64'(r2 - {1'b0, den});
        q_r   <= {q_r[29:0], 1'b1};
      end else begin
        rem_r <= r2[63:0];
        q_r   <= {q_r[29:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (ovf_r) quot = neg_r ? 32'sh8000_0000 : 32'sh7fff_ffff;
    else quot = neg_r ? -$signed(qext) : $signed(qext);
  end

endmodule

### src/ncrc_datapath.sv
// Datapath: configuration registers, iterate, shared multiplier, two divider lanes
// and nearest-root search. Depends on ncrc_pkg and ncrc_divlane.
module ncrc_datapath
  import ncrc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  cfg_idx_t           cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic signed [31:0] in_start_re,
  input  logic signed [31:0] in_start_im,
  input  cmd_t               cmd,
  output status_t            status,
  output logic [1:0]         out_root_index,
  output logic [15:0]        out_iterations_used,
  output logic               out_converged,
  output logic               out_zero_derivative,
  output logic signed [31:0] out_final_re,
  output logic signed [31:0] out_final_im
);

  logic signed [31:0] r0re_r, r0im_r, r1re_r, r1im_r, r2re_r, r2im_r;
  logic [30:0]        tol_r;
  logic [15:0]        maxit_r;

  logic signed [31:0] zr_r, zi_r;
  logic [15:0]        iters_r;
  logic               zder_r, conv_r;
  logic signed [31:0] ar_r, ai_r, br_r, bi_r, cr_r, ci_r;
  logic signed [31:0] t0_r, bcr_r, bci_r, acr_r, aci_r, abr_r, abi_r;
  logic signed [31:0] vr_r, vi_r, dr_r, di_r;
  logic [63:0]        den_r, acc_r;
  logic signed [65:0] hold_r;
  logic [63:0]        mre_r, mim_r;
  logic               nre_r, nim_r;
  logic signed [32:0] er_r, ei_r;
  logic               bound_r;
  logic [1:0]         best_r;
  logic [64:0]        bestd_r;

  logic signed [65:0] p_r;
  logic               pvalid_r;
  mstep_t             pstep_r;

  logic [1:0]         oidx_r;
  logic [15:0]        oit_r;
  logic               oconv_r, ozder_r;
  logic signed [31:0] ore_r, oim_r;

  logic signed [32:0] ma, mb;
  logic signed [31:0] f;
  logic signed [65:0] ssum, smag;
  logic [64:0]        dsum;
  logic signed [31:0] q_re, q_im, nr, ni;
  logic signed [32:0] nr33, ni33, er, ei, tol33;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r0re_r  <= 32'sd268435456;
      r0im_r  <= 32'sd0;
      r1re_r  <= -32'sd134217728;
      r1im_r  <= 32'sd232471924;
      r2re_r  <= -32'sd134217728;
      r2im_r  <= -32'sd232471924;
      tol_r   <= 31'd27;
      maxit_r <= 16'd1000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROOT0_RE:  r0re_r  <= cfg_wdata;
        CFG_ROOT0_IM:  r0im_r  <= cfg_wdata;
        CFG_ROOT1_RE:  r1re_r  <= cfg_wdata;
        CFG_ROOT1_IM:  r1im_r  <= cfg_wdata;
        CFG_ROOT2_RE:  r2re_r  <= cfg_wdata;
        CFG_ROOT2_IM:  r2im_r  <= cfg_wdata;
        CFG_TOLERANCE: tol_r   <= cfg_wdata[30:0];
        CFG_MAX_ITER:  maxit_r <= cfg_wdata[15:0];
        default:       maxit_r <= maxit_r;
      endcase
    end
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.mstep)
      MS_BR_CR:  begin ma = ext33(br_r);  mb = ext33(cr_r);  end
      MS_BI_CI:  begin ma = ext33(bi_r);  mb = ext33(ci_r);  end
      MS_BR_CI:  begin ma = ext33(br_r);  mb = ext33(ci_r);  end
      MS_BI_CR:  begin ma = ext33(bi_r);  mb = ext33(cr_r);  end
      MS_AR_CR:  begin ma = ext33(ar_r);  mb = ext33(cr_r);  end
      MS_AI_CI:  begin ma = ext33(ai_r);  mb = ext33(ci_r);  end
      MS_AR_CI:  begin ma = ext33(ar_r);  mb = ext33(ci_r);  end
      MS_AI_CR:  begin ma = ext33(ai_r);  mb = ext33(cr_r);  end
      MS_AR_BR:  begin ma = ext33(ar_r);  mb = ext33(br_r);  end
      MS_AI_BI:  begin ma = ext33(ai_r);  mb = ext33(bi_r);  end
      MS_AR_BI:  begin ma = ext33(ar_r);  mb = ext33(bi_r);  end
      MS_AI_BR:  begin ma = ext33(ai_r);  mb = ext33(br_r);  end
      MS_AR_BCR: begin ma = ext33(ar_r);  mb = ext33(bcr_r); end
      MS_AI_BCI: begin ma = ext33(ai_r);  mb = ext33(bci_r); end
      MS_AR_BCI: begin ma = ext33(ar_r);  mb = ext33(bci_r); end
      MS_AI_BCR: begin ma = ext33(ai_r);  mb = ext33(bcr_r); end
      MS_DR_DR:  begin ma = ext33(dr_r);  mb = ext33(dr_r);  end
      MS_DI_DI:  begin ma = ext33(di_r);  mb = ext33(di_r);  end
      MS_VR_DR:  begin ma = ext33(vr_r);  mb = ext33(dr_r);  end
      MS_VI_DI:  begin ma = ext33(vi_r);  mb = ext33(di_r);  end
      MS_VI_DR:  begin ma = ext33(vi_r);  mb = ext33(dr_r);  end
      MS_VR_DI:  begin ma = ext33(vr_r);  mb = ext33(di_r);  end
      MS_ER_ER:  begin ma = er_r;         mb = er_r;         end
      MS_EI_EI:  begin ma = ei_r;         mb = ei_r;         end
      MS_TOL_SQ: begin ma = tol33;        mb = tol33;        end
      MS_DX0, MS_DY0: begin
        ma = (cmd.mstep == MS_DX0) ? ext33(zr_r) - ext33(r0re_r) : ext33(zi_r) - ext33(r0im_r);
        mb = ma;
      end
      MS_DX1, MS_DY1: begin
        ma = (cmd.mstep == MS_DX1) ? ext33(zr_r) - ext33(r1re_r) : ext33(zi_r) - ext33(r1im_r);
        mb = ma;
      end
      MS_DX2, MS_DY2: begin
        ma = (cmd.mstep == MS_DX2) ? ext33(zr_r) - ext33(r2re_r) : ext33(zi_r) - ext33(r2im_r);
        mb = ma;
      end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pvalid_r <= 1'b0;
    else pvalid_r <= cmd.mul_en;
    p_r     <= ma * mb;
    pstep_r <= cmd.mstep;
  end

  assign f     = fmul(p_r);
  assign ssum  = (pstep_r == MS_VR_DI) ? hold_r - p_r : hold_r + p_r;
  assign smag  = ssum[65] ? -ssum : ssum;
  assign dsum  = hold_r[64:0] + p_r[64:0];
  assign tol33 = {2'b00, tol_r};

  always_ff @(posedge clk) begin
    if (pvalid_r) begin
      case (pstep_r)
        MS_BR_CR, MS_BR_CI, MS_AR_CR, MS_AR_CI, MS_AR_BR, MS_AR_BI, MS_AR_BCR, MS_AR_BCI:
          t0_r <= f;
        MS_BI_CI:  bcr_r <= sat_sub(t0_r, f);
        MS_BI_CR:  bci_r <= sat_add(t0_r, f);
        MS_AI_CI:  acr_r <= sat_sub(t0_r, f);
        MS_AI_CR:  aci_r <= sat_add(t0_r, f);
        MS_AI_BI:  abr_r <= sat_sub(t0_r, f);
        MS_AI_BR:  abi_r <= sat_add(t0_r, f);
        MS_AI_BCI: begin
          vr_r <= sat_sub(t0_r, f);
          dr_r <= sat_add(sat_add(bcr_r, acr_r), abr_r);
          di_r <= sat_add(sat_add(bci_r, aci_r), abi_r);
        end
        MS_AI_BCR: vi_r  <= sat_add(t0_r, f);
        MS_DR_DR:  den_r <= p_r[63:0];
        MS_DI_DI:  den_r <= den_r + p_r[63:0];
        MS_VR_DR, MS_VI_DR, MS_DX0, MS_DX1, MS_DX2: hold_r <= p_r;
        MS_VI_DI:  begin mre_r <= smag[63:0]; nre_r <= ssum[65]; end
        MS_VR_DI:  begin mim_r <= smag[63:0]; nim_r <= ssum[65]; end
        MS_ER_ER:  acc_r <= p_r[63:0];
        MS_EI_EI:  acc_r <= acc_r + p_r[63:0];
        MS_DY0:    begin best_r <= 2'd0; bestd_r <= dsum; end
        MS_DY1:    if (dsum < bestd_r) begin best_r <= 2'd1; bestd_r <= dsum; end
        MS_DY2:    if (dsum < bestd_r) begin best_r <= 2'd2; bestd_r <= dsum; end
        default:   t0_r <= t0_r;
      endcase
    end
  end

  ncrc_divlane u_div_re (
    .clk  (clk),
    .init (cmd.div_init),
    .step (cmd.div_step),
    .mag  (mre_r),
    .neg  (nre_r),
    .den  (den_r),
    .quot (q_re)
  );

  ncrc_divlane u_div_im (
    .clk  (clk),
    .init (cmd.div_init),
    .step (cmd.div_step),
    .mag  (mim_r),
    .neg  (nim_r),
    .den  (den_r),
    .quot (q_im)
  );

  assign nr33 = ext33(zr_r) - ext33(q_re);
  assign ni33 = ext33(zi_r) - ext33(q_im);
  assign nr   = sat32({{33{nr33[32]}}, nr33});
  assign ni   = sat32({{33{ni33[32]}}, ni33});
  assign er   = ext33(nr) - ext33(zr_r);
  assign ei   = ext33(ni) - ext33(zi_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      zr_r    <= in_start_re;
      zi_r    <= in_start_im;
      iters_r <= '0;
      zder_r  <= 1'b0;
      conv_r  <= 1'b0;
    end else begin
      if (cmd.upd) begin
        zr_r    <= nr;
        zi_r    <= ni;
        er_r    <= er;
        ei_r    <= ei;
        bound_r <= (er <= tol33) && (er >= -tol33) && (ei <= tol33) && (ei >= -tol33);
        iters_r <= iters_r + 16'd1;
      end
      if (cmd.set_zder) zder_r <= 1'b1;
      if (pvalid_r && pstep_r == MS_TOL_SQ) conv_r <= bound_r && (acc_r <= p_r[63:0]);
    end
    if (cmd.abc) begin
      ar_r <= sat_sub(zr_r, r0re_r);
      ai_r <= sat_sub(zi_r, r0im_r);
      br_r <= sat_sub(zr_r, r1re_r);
      bi_r <= sat_sub(zi_r, r1im_r);
      cr_r <= sat_sub(zr_r, r2re_r);
      ci_r <= sat_sub(zi_r, r2im_r);
    end
    if (cmd.out_load) begin
      oidx_r  <= best_r;
      oit_r   <= iters_r;
      oconv_r <= conv_r;
      ozder_r <= zder_r;
      ore_r   <= zr_r;
      oim_r   <= zi_r;
    end
  end

  assign status.at_limit = (iters_r >= maxit_r);
  assign status.den_zero = (den_r == 64'd0);
  assign status.conv     = conv_r;

  assign out_root_index      = oidx_r;
  assign out_iterations_used = oit_r;
  assign out_converged       = oconv_r;
  assign out_zero_derivative = ozder_r;
  assign out_final_re        = ore_r;
  assign out_final_im        = oim_r;

endmodule

### src/ncrc_ctrl.sv
// Controller state machine: sequences multiplier steps, divisions and the handshakes.
// Depends on ncrc_pkg.
module ncrc_ctrl
  import ncrc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t     state_r, state_nxt;
  mstep_t     step_r, step_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic       ovalid_r, ovalid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      step_r   <= MS_BR_CR;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      step_r   <= step_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.mstep = step_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_TEST;
        end
      end
      S_TEST: begin
        if (status.at_limit) begin
          step_nxt  = MS_DX0;
          state_nxt = S_MUL_D;
        end else begin
          state_nxt = S_ABC;
        end
      end
      S_ABC: begin
        cmd.abc   = 1'b1;
        step_nxt  = MS_BR_CR;
        state_nxt = S_MUL_A;
      end
      S_MUL_A: begin
        cmd.mul_en = 1'b1;
        if (step_r == MS_VR_DI) state_nxt = S_CHK;
        else step_nxt = mstep_t'(step_r + 5'd1);
      end
      S_CHK: begin
        if (status.den_zero) begin
          cmd.set_zder = 1'b1;
          step_nxt     = MS_DX0;
          state_nxt    = S_MUL_D;
        end else begin
          state_nxt = S_DIVI;
        end
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 5'd1;
        if (cnt_r == 5'(DIV_STEPS - 1)) state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        step_nxt  = MS_ER_ER;
        state_nxt = S_MUL_C;
      end
      S_MUL_C: begin
        cmd.mul_en = 1'b1;
        if (step_r == MS_TOL_SQ) state_nxt = S_CONVW;
        else step_nxt = mstep_t'(step_r + 5'd1);
      end
      S_CONVW: state_nxt = S_DEC;
      S_DEC: begin
        if (status.conv) begin
          step_nxt  = MS_DX0;
          state_nxt = S_MUL_D;
        end else begin
          state_nxt = S_TEST;
        end
      end
      S_MUL_D: begin
        cmd.mul_en = 1'b1;
        if (step_r == MS_DY2) state_nxt = S_DISTW;
        else step_nxt = mstep_t'(step_r + 5'd1);
      end
      S_DISTW: state_nxt = S_FIN;
      S_FIN: begin
        if (!ovalid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    ovalid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : ovalid_r);
  end

  assign out_valid = ovalid_r;

endmodule

### src/ncrc_checker.sv
// Port-level checks for the Newton cubic root classifier, bound to the top level.
// Depends only on the top level's ports.
module ncrc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_root_index,
  input logic [15:0] out_iterations_used,
  input logic        out_converged,
  input logic        out_zero_derivative,
  input logic [31:0] out_final_re,
  input logic [31:0] out_final_im
);

  // A stalled result beat holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_final_re) && $stable(out_final_im)
      && $stable(out_iterations_used) && $stable(out_root_index))
    else $error("stalled result changed");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_root_index != 2'd3)
    else $error("root index out of range");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_converged && out_zero_derivative))
    else $error("converged and zero derivative both set");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a second point while busy");

  a_conv_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_converged |-> out_iterations_used != 16'd0)
    else $error("converged without a step");

endmodule

bind newton_cubic_root_classifier ncrc_checker u_chk (.*);

### tb/tb.sv
// Self-checking testbench for the Newton cubic root classifier.
// It predicts each result in fixed point, then compares it with the block's output beat.
// Depends on ncrc_pkg and newton_cubic_root_classifier.
`timescale 1ns / 1ps

module tb
  import ncrc_pkg::*;
();

  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
  } point_t;

  typedef struct {
    logic [1:0]         root_index;
    logic [15:0]        iterations_used;
    logic               converged;
    logic               zero_derivative;
    logic signed [31:0] final_re;
    logic signed [31:0] final_im;
  } class_res_t;

  localparam int WATCHDOG_LIMIT = 20000000;
  localparam logic signed [31:0] ONE_Q = 32'sd268435456;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] in_start_re;
  logic signed [31:0] in_start_im;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_root_index;
  logic [15:0]        out_iterations_used;
  logic               out_converged;
  logic               out_zero_derivative;
  logic signed [31:0] out_final_re;
  logic signed [31:0] out_final_im;

  point_t     start_q[$];
  class_res_t class_q[$];
  int         fail_cnt;
  int         stall_cnt;
  bit         idle_on;

  logic signed [31:0] root_re[3];
  logic signed [31:0] root_im[3];
  logic [30:0]        tol_reg;
  logic [15:0]        iter_limit;

  newton_cubic_root_classifier i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_start_re         (in_start_re),
    .in_start_im         (in_start_im),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_root_index      (out_root_index),
    .out_iterations_used (out_iterations_used),
    .out_converged       (out_converged),
    .out_zero_derivative (out_zero_derivative),
    .out_final_re        (out_final_re),
    .out_final_im        (out_final_im)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint qmul(longint a, longint b);
    longint p;
    p = a * b;
    return clamp32(p >>> FRAC_BITS);
  endfunction

  function automatic logic [63:0] mag_sq(longint x);
    logic [63:0] m;
    m = (x < 0) ? 64'(-x) : 64'(x);
    return m * m;
  endfunction

  function automatic longint qdiv(logic signed [65:0] num, logic [63:0] den);
    logic [127:0] m;
    logic [127:0] q;
    m = (num < 0) ? 128'(-num) : 128'(num);
    q = (m << FRAC_BITS) / {64'd0, den};
    if (q >= 128'h8000_0000) q = 128'h8000_0000;
    if (num < 0) return -longint'(q[32:0]);
    return (q > 128'h7FFF_FFFF) ? 64'sd2147483647 : longint'(q[32:0]);
  endfunction

  function automatic class_res_t classify_point(point_t pt);
    class_res_t  res;
    longint      zr, zi, ar, ai, br, bi, cr, ci, bcr, bci, acr, aci, abr, abi;
    longint      vr, vi, dr, di, nr, ni, er, ei, t;
    logic [63:0] den;
    logic [64:0] sq_dist, best_dist;
    int unsigned steps;
    zr = pt.re;
    zi = pt.im;
    steps = 0;
    res.converged = 1'b0;
    res.zero_derivative = 1'b0;
    t = longint'(tol_reg);
    while (steps < iter_limit) begin
      ar = clamp32(zr - root_re[0]); ai = clamp32(zi - root_im[0]);
      br = clamp32(zr - root_re[1]); bi = clamp32(zi - root_im[1]);
      cr = clamp32(zr - root_re[2]); ci = clamp32(zi - root_im[2]);
      bcr = clamp32(qmul(br, cr) - qmul(bi, ci));
      bci = clamp32(qmul(br, ci) + qmul(bi, cr));
      acr = clamp32(qmul(ar, cr) - qmul(ai, ci));
      aci = clamp32(qmul(ar, ci) + qmul(ai, cr));
      abr = clamp32(qmul(ar, br) - qmul(ai, bi));
      abi = clamp32(qmul(ar, bi) + qmul(ai, br));
      vr = clamp32(qmul(ar, bcr) - qmul(ai, bci));
      vi = clamp32(qmul(ar, bci) + qmul(ai, bcr));
      dr = clamp32(clamp32(bcr + acr) + abr);
      di = clamp32(clamp32(bci + aci) + abi);
      den = mag_sq(dr) + mag_sq(di);
      if (den == 0) begin
        res.zero_derivative = 1'b1;
        break;
      end
      nr = clamp32(zr - qdiv(66'(vr * dr) + 66'(vi * di), den));
      ni = clamp32(zi - qdiv(66'(vi * dr) - 66'(vr * di), den));
      er = nr - zr;
      ei = ni - zi;
      zr = nr;
      zi = ni;
      steps++;
      if (er <= t && er >= -t && ei <= t && ei >= -t &&
          mag_sq(er) + mag_sq(ei) <= 64'(t) * 64'(t)) begin
        res.converged = 1'b1;
        break;
      end
    end
    res.root_index = 2'd0;
    best_dist = '0;
    for (int k = 0; k < 3; k++) begin
      sq_dist = {1'b0, mag_sq(zr - root_re[k])} + {1'b0, mag_sq(zi - root_im[k])};
      if (k == 0 || sq_dist < best_dist) begin
        res.root_index = 2'(k);
        best_dist = sq_dist;
      end
    end
    res.iterations_used = steps[15:0];
    res.final_re = zr[31:0];
    res.final_im = zi[31:0];
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid    <= 1'b0;
      in_start_re <= '0;
      in_start_im <= '0;
    end else begin
      if (in_valid && in_ready) begin
        class_q.insert(class_q.size(), classify_point('{re: in_start_re, im: in_start_im}));
      end
      if (!in_valid || in_ready) begin
        if (start_q.size() > 0 && !(idle_on && $urandom_range(99) < 28)) begin
          in_valid    <= 1'b1;
          in_start_re <= start_q[0].re;
          in_start_im <= start_q[0].im;
          start_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    class_res_t exp_r;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(idle_on && $urandom_range(99) < 28);
      if (out_valid && out_ready) begin
        if (class_q.size() == 0) begin
          $error("unexpected result beat");
          fail_cnt++;
        end else begin
          exp_r = class_q.pop_front();
          check_field("root_index", exp_r.root_index, out_root_index);
          check_field("iterations_used", exp_r.iterations_used, out_iterations_used);
          check_field("converged", exp_r.converged, out_converged);
          check_field("zero_derivative", exp_r.zero_derivative, out_zero_derivative);
          check_field("final_re", exp_r.final_re, out_final_re);
          check_field("final_im", exp_r.final_im, out_final_im);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (!in_valid && class_q.size() == 0)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= WATCHDOG_LIMIT) begin
        $display("newton_cubic_root_classifier regression: fail");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_ROOT0_RE:  root_re[0] = val;
      CFG_ROOT0_IM:  root_im[0] = val;
      CFG_ROOT1_RE:  root_re[1] = val;
      CFG_ROOT1_IM:  root_im[1] = val;
      CFG_ROOT2_RE:  root_re[2] = val;
      CFG_ROOT2_IM:  root_im[2] = val;
      CFG_TOLERANCE: tol_reg = val[30:0];
      default:       iter_limit = val[15:0];
    endcase
  endtask

  task automatic set_config(logic signed [31:0] r0r, logic signed [31:0] r0i,
                            logic signed [31:0] r1r, logic signed [31:0] r1i,
                            logic signed [31:0] r2r, logic signed [31:0] r2i,
                            logic [31:0] tol, logic [31:0] lim);
    write_reg(CFG_ROOT0_RE, r0r);
    write_reg(CFG_ROOT0_IM, r0i);
    write_reg(CFG_ROOT1_RE, r1r);
    write_reg(CFG_ROOT1_IM, r1i);
    write_reg(CFG_ROOT2_RE, r2r);
    write_reg(CFG_ROOT2_IM, r2i);
    write_reg(CFG_TOLERANCE, tol);
    write_reg(CFG_MAX_ITER, lim);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (start_q.size() > 0 || in_valid || class_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic add_point(logic signed [31:0] re, logic signed [31:0] im);
    start_q.insert(start_q.size(), '{re: re, im: im});
  endtask

  function automatic logic signed [31:0] near_q(int unsigned span);
    return $signed($urandom_range(2 * span)) - $signed(span);
  endfunction

  initial begin
    logic [31:0] tol_pick;
    fail_cnt  = 0;
    idle_on   = 1'b1;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    root_re   = '{32'sd268435456, -32'sd134217728, -32'sd134217728};
    root_im   = '{32'sd0, 32'sd232471924, -32'sd232471924};
    tol_reg   = 31'd27;
    iter_limit = 16'd1000;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset roots: origin has a zero derivative, the roots converge at once.
    add_point(0, 0);
    add_point(root_re[0], root_im[0]);
    add_point(root_re[1], root_im[1]);
    add_point(root_re[2], root_im[2]);
    add_point(ONE_Q + 1000, -32'sd5000);
    add_point(-32'sd300000000, 32'sd20000000);
    add_point(32'sd100000000, 32'sd400000000);
    wait_drained();

    set_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
               32'sd0, 32'sd0, 32'h8000_0000, 32'd20);
    add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_point(32'h8000_0000, 32'h8000_0000);
    add_point(32'h7FFF_FFFF, 32'h8000_0000);
    add_point(32'h8000_0000, 32'h7FFF_FFFF);
    add_point(32'hFFFF_FFFF, 32'h0000_0001);
    add_point(0, 0);
    wait_drained();

    set_config(ONE_Q, 0, -ONE_Q, 0, 0, ONE_Q, 32'h7FFF_FFFF, 32'd0);
    add_point(32'h7FFF_FFFF, 32'h8000_0000);
    add_point(ONE_Q, 0);
    add_point(near_q(32'h7FFF_FFFF), near_q(32'h7FFF_FFFF));
    wait_drained();

    // Triple root: a start on it stops on the zero derivative, others in one step.
    set_config(ONE_Q / 2, 0, ONE_Q / 2, 0, ONE_Q / 2, 0, 32'h7FFF_FFFF, 32'd65535);
    add_point(ONE_Q / 2, 0);
    for (int i = 0; i < 4; i++) add_point(near_q(ONE_Q / 2), near_q(ONE_Q / 2));
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(3))
        0:       tol_pick = 32'd0;
        1:       tol_pick = {1'($urandom_range(1)), 31'd27};
        2:       tol_pick = $urandom_range(1 << 20, 1);
        default: tol_pick = $urandom();
      endcase
      if (ph == 0) begin
        set_config(ONE_Q, 0, -ONE_Q / 2, 32'sd232471924, -ONE_Q / 2, -32'sd232471924,
                   32'd27, {16'($urandom_range(65535)), 16'd30});
      end else begin
        set_config(near_q(ONE_Q * 2), near_q(ONE_Q * 2), near_q(ONE_Q * 2),
                   near_q(ONE_Q * 2), near_q(ONE_Q * 2), near_q(ONE_Q * 2),
                   tol_pick, {16'($urandom()), 16'($urandom_range(24, 1))});
      end
      idle_on = (ph != 3);
      for (int i = 0; i < 100; i++) begin
        if ($urandom_range(9) < 7) add_point(near_q(ONE_Q * 2), near_q(ONE_Q * 2));
        else add_point($urandom(), $urandom());
      end
      wait_drained();
    end

    repeat (200) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("newton_cubic_root_classifier regression: pass");
    end else begin
      $display("newton_cubic_root_classifier regression: fail");
    end
    $finish;
  end

endmodule
